### hw/rtl/flhc_pkg.sv
// Flow log hit counter: shared constants, codes and beat/entry types.
// No dependencies.
package flhc_pkg;

  localparam int LOG_DEPTH = 64;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int SLOT_W    = 6;
  localparam int USED_W    = 7;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic MODE_LOG   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  reason;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [2:0]  verdict;
    logic [2:0]  hook_number;
    logic [31:0] now_seconds;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       hit_count;
    logic [USED_W-1:0] used_entries;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  reason;
    logic [7:0]  protocol;
    logic [2:0]  verdict;
    logic [2:0]  hook;
    logic [31:0] last_seen;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] used;
  } stat_t;

endpackage

### hw/rtl/flhc_if.sv
// Valid/ready channel interfaces for log items and results.
// Depends on flhc_pkg.
interface flhc_in_if import flhc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface flhc_out_if import flhc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/flhc_table.sv
// Entry store: one write port, one read port with registered read data.
// Depends on flhc_pkg.
module flhc_table import flhc_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [LOG_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/flhc_ctrl.sv
// Sequencer: scans the table one entry per cycle through the key compare,
// then updates or inserts one slot, drops or clears, and registers the result beat.
// Depends on flhc_pkg and flhc_if.
module flhc_ctrl import flhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  flhc_in_if.sink    in_i,
  flhc_out_if.source out_o,
  output mem_req_t   mem_req_o,
  input  entry_t     mem_rdata_i,
  output stat_t      stat_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HIT  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pend_idx_q, pend_idx_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;
  in_beat_t         key_q, key_d;
  logic [31:0]      cnt_q, cnt_d;
  logic [2:0]       hook_q, hook_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  logic             match;
  logic             last;
  logic             out_free;
  logic [31:0]      cnt_inc;

  assign match = pend_q &&
                 mem_rdata_i.src_ip   == key_q.src_ip   &&
                 mem_rdata_i.dst_ip   == key_q.dst_ip   &&
                 mem_rdata_i.sport    == key_q.sport    &&
                 mem_rdata_i.dport    == key_q.dport    &&
                 mem_rdata_i.reason   == key_q.reason   &&
                 mem_rdata_i.protocol == key_q.protocol &&
                 mem_rdata_i.verdict  == key_q.verdict;
  assign last     = (pend_idx_q + CNT_W'(1)) == used_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    pend_idx_d  = pend_idx_q;
    pend_d      = pend_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    hook_d      = hook_q;
    slot_d      = slot_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    in_i.ready  = 1'b0;

    mem_req_o                 = '0;
    mem_req_o.wdata.src_ip    = key_q.src_ip;
    mem_req_o.wdata.dst_ip    = key_q.dst_ip;
    mem_req_o.wdata.sport     = key_q.sport;
    mem_req_o.wdata.dport     = key_q.dport;
    mem_req_o.wdata.reason    = key_q.reason;
    mem_req_o.wdata.protocol  = key_q.protocol;
    mem_req_o.wdata.verdict   = key_q.verdict;
    mem_req_o.wdata.hook      = key_q.hook_number;
    mem_req_o.wdata.last_seen = key_q.now_seconds;
    mem_req_o.wdata.count     = 32'd1;
    mem_req_o.raddr           = idx_q[IDX_W-1:0];
    mem_req_o.waddr           = used_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          key_d  = in_i.data;
          idx_d  = '0;
          pend_d = 1'b0;
          if (in_i.data.mode == MODE_CLEAR) begin
            state_d = S_CLR;
          end else if (used_q == '0) begin
            state_d = S_MISS;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_req_o.re = idx_q < used_q;
        pend_d       = 1'b1;
        pend_idx_d   = idx_q;
        idx_d        = idx_q + CNT_W'(1);
        if (match) begin
          slot_d  = pend_idx_q;
          cnt_d   = mem_rdata_i.count;
          hook_d  = mem_rdata_i.hook;
          pend_d  = 1'b0;
          state_d = S_HIT;
        end else if (pend_q && last) begin
          pend_d  = 1'b0;
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        if (out_free) begin
          mem_req_o.we          = 1'b1;
          mem_req_o.waddr       = slot_q[IDX_W-1:0];
          mem_req_o.wdata.hook  = hook_q;
          mem_req_o.wdata.count = cnt_inc;
          out_d.status          = ST_UPDATED;
          out_d.slot            = SLOT_W'(slot_q);
          out_d.hit_count       = cnt_inc;
          out_d.used_entries    = USED_W'(used_q);
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (used_q == CNT_W'(LOG_DEPTH)) begin
            out_d.status       = ST_DROPPED;
            out_d.slot         = '0;
            out_d.hit_count    = '0;
            out_d.used_entries = USED_W'(used_q);
          end else begin
            mem_req_o.we       = 1'b1;
            used_d             = used_q + CNT_W'(1);
            out_d.status       = ST_NEW;
            out_d.slot         = SLOT_W'(used_q);
            out_d.hit_count    = 32'd1;
            out_d.used_entries = USED_W'(used_d);
          end
        end
      end
      S_CLR: begin
        if (out_free) begin
          used_d             = '0;
          out_d.status       = ST_CLEARED;
          out_d.slot         = '0;
          out_d.hit_count    = '0;
          out_d.used_entries = '0;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      pend_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      pend_idx_q  <= pend_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    cnt_q  <= cnt_d;
    hook_q <= hook_d;
    slot_q <= slot_d;
    out_q  <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign stat_o.busy = state_q != S_IDLE;
  assign stat_o.used = used_q;

endmodule

### hw/rtl/flow_log_hit_counter_core.sv
// Flow log hit counter top level: sequencer plus entry store.
// Depends on flhc_pkg, flhc_if, flhc_table and flhc_ctrl.
//
// Logs packet events into a table of LOG_DEPTH entries keyed on reason,
// protocol, addresses, ports and verdict. Each log beat is compared against
// the valid entries one per cycle through the single read port of the table.
// A miss scans every valid entry, a hit stops the scan at its slot, and a log
// item into an empty table or a clear item skips the scan; a result is only
// written once the previous one has left the output register.
// A hit refreshes the timestamp and bumps the saturating count; a miss
// inserts at the next free slot, or is dropped with status 2 when the table
// is full. The result register lets a new item be accepted while the
// previous result waits. No clearing pass is needed after reset.
module flow_log_hit_counter_core import flhc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  flhc_in_if.sink    in_i,
  flhc_out_if.source out_o
);

  mem_req_t mem_req;
  entry_t   mem_rdata;
  stat_t    stat;

  flhc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .stat_o      (stat)
  );

  flhc_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.used <= CNT_W'(LOG_DEPTH))
    else $error("entry count above table depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready && stat.busy)
    else $error("ready while an item is in flight");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status == ST_CLEARED |->
      out_o.data.used_entries == '0 && stat.used == '0)
    else $error("clear result with entries left");

  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status == ST_NEW |->
      out_o.data.hit_count == 32'd1 && out_o.data.used_entries != '0)
    else $error("bad new-entry result");

endmodule

### bench/flow_log_hit_counter_core_test.sv
// Self-checking bench for flow_log_hit_counter_core: directed table plus random flow traffic.
// Depends on flhc_pkg, flhc_if and the core RTL.
module flow_log_hit_counter_core_test;
  import flhc_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int SEGMENTS       = 12;
  localparam int SEG_ITEMS      = 100;
  localparam int HOLD_OFF       = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = LOG_DEPTH + 8;
  localparam int PRINT_CAP      = 100;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // match key; hook number is stored but never compared
  typedef struct packed {
    logic [7:0]  reason;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [2:0]  verdict;
  } flow_key_t;

  localparam int KEY_W = $bits(flow_key_t);

  typedef struct {
    in_beat_t  item;
    bit        typed;
    out_beat_t want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  flhc_in_if  in_if ();
  flhc_out_if out_if ();

  flow_log_hit_counter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  flow_key_t   tbl_key  [LOG_DEPTH];
  logic [2:0]  tbl_hook [LOG_DEPTH];
  logic [31:0] tbl_seen [LOG_DEPTH];
  logic [31:0] tbl_hits [LOG_DEPTH];
  int unsigned tbl_used = 0;

  out_beat_t   outcome_q[$];
  plan_row_t   plan[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  int          idle_pct     = 0;
  bit          long_hold_req = 1'b0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  function automatic in_beat_t mk_item(logic mode, logic [7:0] reason, logic [7:0] protocol,
                                       logic [31:0] src_ip, logic [31:0] dst_ip,
                                       logic [15:0] sport, logic [15:0] dport,
                                       logic [2:0] verdict, logic [2:0] hook,
                                       logic [31:0] now);
    in_beat_t it;
    it.mode        = mode;
    it.reason      = reason;
    it.protocol    = protocol;
    it.src_ip      = src_ip;
    it.dst_ip      = dst_ip;
    it.sport       = sport;
    it.dport       = dport;
    it.verdict     = verdict;
    it.hook_number = hook;
    it.now_seconds = now;
    return it;
  endfunction

  function automatic out_beat_t mk_out(logic [1:0] status, int slot, logic [31:0] hits, int used);
    out_beat_t r;
    r.status       = status;
    r.slot         = SLOT_W'(slot);
    r.hit_count    = hits;
    r.used_entries = USED_W'(used);
    return r;
  endfunction

  function automatic out_beat_t predict_outcome(in_beat_t it);
    out_beat_t r;
    flow_key_t k;
    int        hit;
    r   = '0;
    hit = -1;
    k.reason   = it.reason;
    k.protocol = it.protocol;
    k.src_ip   = it.src_ip;
    k.dst_ip   = it.dst_ip;
    k.sport    = it.sport;
    k.dport    = it.dport;
    k.verdict  = it.verdict;
    if (it.mode == MODE_CLEAR) begin
      tbl_used = 0;
      r.status = ST_CLEARED;
    end else begin
      for (int i = 0; i < tbl_used; i++)
        if (hit < 0 && tbl_key[i] == k) hit = i;
      if (hit >= 0) begin
        tbl_seen[hit] = it.now_seconds;
        if (tbl_hits[hit] != COUNT_MAX) tbl_hits[hit]++;
        r.status    = ST_UPDATED;
        r.slot      = SLOT_W'(hit);
        r.hit_count = tbl_hits[hit];
      end else if (tbl_used == LOG_DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        tbl_key[tbl_used]  = k;
        tbl_hook[tbl_used] = it.hook_number;
        tbl_seen[tbl_used] = it.now_seconds;
        tbl_hits[tbl_used] = 32'd1;
        r.status    = ST_NEW;
        r.slot      = SLOT_W'(tbl_used);
        r.hit_count = 32'd1;
        tbl_used++;
      end
    end
    r.used_entries = USED_W'(tbl_used);
    return r;
  endfunction

  // hits reuse a stored key, near misses flip one key bit of a stored key
  function automatic in_beat_t draw_item(int clear_pct, int hit_pct, int near_pct);
    in_beat_t  it;
    flow_key_t k;
    int        roll;
    roll       = $urandom_range(0, 99);
    k.reason   = 8'($urandom);
    k.protocol = 8'($urandom);
    k.src_ip   = $urandom;
    k.dst_ip   = $urandom;
    k.sport    = 16'($urandom);
    k.dport    = 16'($urandom);
    k.verdict  = 3'($urandom);
    if (tbl_used > 0 && roll >= clear_pct && roll < clear_pct + hit_pct + near_pct) begin
      k = tbl_key[$urandom_range(0, tbl_used - 1)];
      if (roll >= clear_pct + hit_pct) k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
    end
    it = mk_item((roll < clear_pct) ? MODE_CLEAR : MODE_LOG, k.reason, k.protocol,
                 k.src_ip, k.dst_ip, k.sport, k.dport, k.verdict,
                 3'($urandom), $urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
    if (mismatches < PRINT_CAP)
      $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic check_outcome(out_beat_t got);
    out_beat_t want;
    results_seen++;
    if (outcome_q.size() == 0) begin
      report_mismatch("beat with nothing pending", got, 0);
    end else begin
      want = outcome_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.slot !== want.slot)
        report_mismatch("slot", got.slot, want.slot);
      if (got.hit_count !== want.hit_count)
        report_mismatch("hit_count", got.hit_count, want.hit_count);
      if (got.used_entries !== want.used_entries)
        report_mismatch("used_entries", got.used_entries, want.used_entries);
    end
  endtask

  task automatic offer_item(in_beat_t it, bit typed, out_beat_t want);
    out_beat_t predicted;
    int        gap;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predicted = predict_outcome(it);
    outcome_q.push_back(typed ? want : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("[flow_log_hit_counter_core] ERROR");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_outcome(out_if.data);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = HOLD_OFF - 1;
        out_if.ready <= 1'b0;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          hold--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    in_beat_t it;
    in_if.valid = 1'b0;
    in_if.data  = '0;

    plan.push_back('{mk_item(MODE_CLEAR, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'h0), 1'b1, mk_out(ST_CLEARED, 0, 32'd0, 0)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'h0), 1'b1, mk_out(ST_NEW, 0, 32'd1, 1)});
    plan.push_back('{mk_item(MODE_LOG, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                             16'hFFFF, 3'd7, 3'd7, 32'hFFFF_FFFF), 1'b1,
                     mk_out(ST_NEW, 1, 32'd1, 2)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd7,
                             32'hFFFF_FFFF), 1'b1, mk_out(ST_UPDATED, 0, 32'd2, 2)});
    plan.push_back('{mk_item(MODE_LOG, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                             16'hFFFF, 3'd7, 3'd0, 32'h0), 1'b1,
                     mk_out(ST_UPDATED, 1, 32'd2, 2)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd1, 3'd0,
                             32'h1), 1'b1, mk_out(ST_NEW, 2, 32'd1, 3)});
    plan.push_back('{mk_item(MODE_LOG, 8'h80, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'h2), 1'b1, mk_out(ST_NEW, 3, 32'd1, 4)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h01, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'h3), 1'b1, mk_out(ST_NEW, 4, 32'd1, 5)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 3'd0,
                             3'd0, 32'h4), 1'b1, mk_out(ST_NEW, 5, 32'd1, 6)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h1, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'h5), 1'b1, mk_out(ST_NEW, 6, 32'd1, 7)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h8000, 16'h0, 3'd0, 3'd0,
                             32'h6), 1'b1, mk_out(ST_NEW, 7, 32'd1, 8)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h1, 3'd0, 3'd0,
                             32'h7), 1'b1, mk_out(ST_NEW, 8, 32'd1, 9)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd5,
                             32'h8), 1'b1, mk_out(ST_UPDATED, 0, 32'd3, 9)});
    plan.push_back('{mk_item(MODE_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                             16'hFFFF, 3'd7, 3'd7, 32'hFFFF_FFFF), 1'b1,
                     mk_out(ST_CLEARED, 0, 32'd0, 0)});
    plan.push_back('{mk_item(MODE_LOG, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                             16'hFFFF, 3'd7, 3'd7, 32'h9), 1'b1, mk_out(ST_NEW, 0, 32'd1, 1)});
    plan.push_back('{mk_item(MODE_LOG, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 3'd0,
                             32'hA), 1'b1, mk_out(ST_NEW, 1, 32'd1, 2)});
    plan.push_back('{mk_item(MODE_LOG, 8'h5A, 8'h06, 32'hC0A8_0001, 32'h0A00_0001, 16'h1234,
                             16'h0050, 3'd2, 3'd3, 32'h1000), 1'b0, '0});
    plan.push_back('{mk_item(MODE_LOG, 8'h5A, 8'h06, 32'hC0A8_0001, 32'h0A00_0001, 16'h1234,
                             16'h0050, 3'd2, 3'd6, 32'h2000), 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    foreach (plan[i]) offer_item(plan[i].item, plan[i].typed, plan[i].want);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      if (seg == 3) long_hold_req = 1'b1;
      if (seg == 6) begin
        in_if.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        case (seg % 3)
          0:       it = draw_item(0, 25, 5);
          1:       it = draw_item(5, 60, 20);
          default: it = draw_item(1, 40, 20);
        endcase
        offer_item(it, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[flow_log_hit_counter_core] OK");
    end else begin
      $display("[flow_log_hit_counter_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/flhc_pkg.sv
hw/rtl/flhc_if.sv
hw/rtl/flhc_table.sv
hw/rtl/flhc_ctrl.sv
hw/rtl/flow_log_hit_counter_core.sv
bench/flow_log_hit_counter_core_test.sv
